// ----- hw/rtl/nmss_pkg.sv -----
package nmss_pkg;

  localparam int VecW   = 16;
  localparam int ColW   = 16;
  localparam int TexW   = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 16;

  // v = T*e_r + B*e_g + N*e_b fits in 27 signed bits
  localparam int VW     = 27;
  localparam int RemW   = 64;
  localparam int SqrtN  = 32;
  localparam int QW     = 16;
  localparam int NumW   = 48;
  localparam int LenW   = 32;

  localparam logic signed [VecW-1:0] VEC_ONE     = 16'sd16384;
  localparam logic [ColW-1:0]        BASE_RESET  = 16'd4096;
  // floor(x*DIV255_MUL >> DIV255_SH) is x/255 or one above, for x < 2^24
  localparam logic [15:0]            DIV255_MUL  = 16'd32897;
  localparam int                     DIV255_SH   = 23;

  localparam logic [CfgIdxW-1:0] REG_BASE_RED   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BASE_GREEN = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BASE_BLUE  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_USE_TEX    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_USE_MAP    = 3'd4;

  typedef struct packed {
    logic [2:0][VecW-1:0] n;
    logic [2:0][VecW-1:0] b;
    logic [2:0][ColW-1:0] col;
    logic [2:0][VW-1:0]   v;
  } side_t;

endpackage

// ----- hw/rtl/normal_map_shading_setup_unit.sv -----
// Throughput: one word per cycle; the pipe advances whenever the output
//   register is empty or being taken, so in_stall only follows out_stall.
// Reset (rst_n low, synchronous): all valid bits cleared, base color back
//   to 4096 (one), color texturing and normal mapping off.
module normal_map_shading_setup_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [nmss_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [nmss_pkg::CfgDatW-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            in_normal_x,
  input  logic signed [15:0]            in_normal_y,
  input  logic signed [15:0]            in_normal_z,
  input  logic signed [15:0]            in_tangent_x,
  input  logic signed [15:0]            in_tangent_y,
  input  logic signed [15:0]            in_tangent_z,
  input  logic [7:0]                    in_map_red,
  input  logic [7:0]                    in_map_green,
  input  logic [7:0]                    in_map_blue,
  input  logic [7:0]                    in_tex_red,
  input  logic [7:0]                    in_tex_green,
  input  logic [7:0]                    in_tex_blue,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            out_normal_x,
  output logic signed [15:0]            out_normal_y,
  output logic signed [15:0]            out_normal_z,
  output logic signed [15:0]            out_bitangent_x,
  output logic signed [15:0]            out_bitangent_y,
  output logic signed [15:0]            out_bitangent_z,
  output logic [15:0]                   out_color_red,
  output logic [15:0]                   out_color_green,
  output logic [15:0]                   out_color_blue
);
  import nmss_pkg::*;

  // Pipe layout:
  //   p1  cross products, color product base*tex+127, map decode 2t-255
  //   p2  bitangent round/clamp, color /255 estimate
  //   p3  frame products, color correction
  //   p4  v sums
  //   p5  v squares
  //   p6  |v|^2 << 12 -> square root input
  //   32  square root stages, one root bit each
  //   1   divider setup (|v_i|<<20 + len/2)
  //   16  restoring divide stages, three lanes, one quotient bit each
  //   out clamp, sign, mode select, output register

  // ---------------- configuration ----------------
  logic [ColW-1:0] base_r [3];
  logic            use_tex_r, use_map_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r[0] <= BASE_RESET;
      base_r[1] <= BASE_RESET;
      base_r[2] <= BASE_RESET;
      use_tex_r <= 1'b0;
      use_map_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_RED:   base_r[0] <= cfg_data;
        REG_BASE_GREEN: base_r[1] <= cfg_data;
        REG_BASE_BLUE:  base_r[2] <= cfg_data;
        REG_USE_TEX:    use_tex_r <= cfg_data[0];
        REG_USE_MAP:    use_map_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // whole pipe moves together; holds only when a finished word is stalled
  logic en;
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // ---------------- p1 ----------------
  logic signed [VecW-1:0] n_in [3], t_in [3];
  logic [TexW-1:0]        m_in [3], x_in [3];
  logic signed [9:0]      e_nxt [3];
  logic signed [31:0]     pa_nxt [3], pb_nxt [3];
  logic [23:0]            cx_nxt [3];

  always_comb begin
    n_in[0] = in_normal_x;  n_in[1] = in_normal_y;  n_in[2] = in_normal_z;
    t_in[0] = in_tangent_x; t_in[1] = in_tangent_y; t_in[2] = in_tangent_z;
    m_in[0] = in_map_red;   m_in[1] = in_map_green; m_in[2] = in_map_blue;
    x_in[0] = in_tex_red;   x_in[1] = in_tex_green; x_in[2] = in_tex_blue;
    for (int i = 0; i < 3; i++) begin
      e_nxt[i]  = $signed({1'b0, m_in[i], 1'b0}) - 10'sd255;
      pa_nxt[i] = n_in[(i + 1) % 3] * t_in[(i + 2) % 3];
      pb_nxt[i] = n_in[(i + 2) % 3] * t_in[(i + 1) % 3];
      cx_nxt[i] = 24'(base_r[i]) * 24'(x_in[i]) + 24'd127;
    end
  end

  logic                   p1_vld_r;
  logic signed [VecW-1:0] p1_n_r [3], p1_t_r [3];
  logic signed [9:0]      p1_e_r [3];
  logic signed [31:0]     p1_pa_r [3], p1_pb_r [3];
  logic [23:0]            p1_cx_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) p1_vld_r <= 1'b0;
    else if (en) p1_vld_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p1_n_r  <= n_in;
      p1_t_r  <= t_in;
      p1_e_r  <= e_nxt;
      p1_pa_r <= pa_nxt;
      p1_pb_r <= pb_nxt;
      p1_cx_r <= cx_nxt;
    end
  end

  // ---------------- p2 ----------------
  logic signed [VecW-1:0] b_nxt [3];
  logic [16:0]            q0_nxt [3];
  logic signed [32:0]     dif;
  logic [32:0]            dmag;
  logic [18:0]            rq;
  logic [VecW-1:0]        rqc;
  logic [39:0]            cprod;

  always_comb begin
    dif = '0; dmag = '0; rq = '0; rqc = '0; cprod = '0;
    for (int i = 0; i < 3; i++) begin
      dif  = 33'(p1_pa_r[i]) - 33'(p1_pb_r[i]);
      dmag = dif[32] ? 33'(-dif) : 33'(dif);
      rq   = 19'((dmag + 33'd8192) >> 14);
      rqc  = (rq > 19'd16384) ? 16'd16384 : rq[15:0];
      b_nxt[i] = dif[32] ? -$signed(rqc) : $signed(rqc);
      cprod     = 40'(p1_cx_r[i]) * 40'(DIV255_MUL);
      q0_nxt[i] = cprod[DIV255_SH +: 17];
    end
  end

  logic                   p2_vld_r;
  logic signed [VecW-1:0] p2_n_r [3], p2_t_r [3], p2_b_r [3];
  logic signed [9:0]      p2_e_r [3];
  logic [23:0]            p2_cx_r [3];
  logic [16:0]            p2_q0_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) p2_vld_r <= 1'b0;
    else if (en) p2_vld_r <= p1_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p2_n_r  <= p1_n_r;
      p2_t_r  <= p1_t_r;
      p2_b_r  <= b_nxt;
      p2_e_r  <= p1_e_r;
      p2_cx_r <= p1_cx_r;
      p2_q0_r <= q0_nxt;
    end
  end

  // ---------------- p3 ----------------
  logic signed [25:0] tv_nxt [3], bv_nxt [3], nv_nxt [3];
  logic [ColW-1:0]    col_nxt [3];
  logic [24:0]        q255;
  logic [16:0]        qc;

  always_comb begin
    q255 = '0; qc = '0;
    for (int i = 0; i < 3; i++) begin
      tv_nxt[i] = 26'(p2_t_r[i]) * 26'(p2_e_r[0]);
      bv_nxt[i] = 26'(p2_b_r[i]) * 26'(p2_e_r[1]);
      nv_nxt[i] = 26'(p2_n_r[i]) * 26'(p2_e_r[2]);
      q255 = {p2_q0_r[i], 8'd0} - 25'(p2_q0_r[i]);
      qc   = (q255 > 25'(p2_cx_r[i])) ? p2_q0_r[i] - 17'd1 : p2_q0_r[i];
      col_nxt[i] = use_tex_r ? qc[15:0] : base_r[i];
    end
  end

  logic                   p3_vld_r;
  logic signed [VecW-1:0] p3_n_r [3], p3_b_r [3];
  logic [ColW-1:0]        p3_col_r [3];
  logic signed [25:0]     p3_tv_r [3], p3_bv_r [3], p3_nv_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) p3_vld_r <= 1'b0;
    else if (en) p3_vld_r <= p2_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p3_n_r   <= p2_n_r;
      p3_b_r   <= p2_b_r;
      p3_col_r <= col_nxt;
      p3_tv_r  <= tv_nxt;
      p3_bv_r  <= bv_nxt;
      p3_nv_r  <= nv_nxt;
    end
  end

  // ---------------- p4: v sums ----------------
  logic                   p4_vld_r;
  logic signed [VecW-1:0] p4_n_r [3], p4_b_r [3];
  logic [ColW-1:0]        p4_col_r [3];
  logic signed [VW-1:0]   p4_v_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) p4_vld_r <= 1'b0;
    else if (en) p4_vld_r <= p3_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p4_n_r   <= p3_n_r;
      p4_b_r   <= p3_b_r;
      p4_col_r <= p3_col_r;
      for (int i = 0; i < 3; i++)
        p4_v_r[i] <= VW'(p3_tv_r[i]) + VW'(p3_bv_r[i]) + VW'(p3_nv_r[i]);
    end
  end

  // ---------------- p5: squares ----------------
  logic                   p5_vld_r;
  logic signed [VecW-1:0] p5_n_r [3], p5_b_r [3];
  logic [ColW-1:0]        p5_col_r [3];
  logic signed [VW-1:0]   p5_v_r [3];
  logic [51:0]            p5_sq_r [3];
  logic signed [25:0]     vn [3];

  always_comb begin
    for (int i = 0; i < 3; i++) vn[i] = p4_v_r[i][25:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p5_vld_r <= 1'b0;
    else if (en) p5_vld_r <= p4_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p5_n_r   <= p4_n_r;
      p5_b_r   <= p4_b_r;
      p5_col_r <= p4_col_r;
      p5_v_r   <= p4_v_r;
      for (int i = 0; i < 3; i++)
        p5_sq_r[i] <= 52'(vn[i] * vn[i]);
    end
  end

  // ---------------- p6 + square root ----------------
  logic [RemW-1:0] sq_rem_r  [0:SqrtN];
  logic [RemW-1:0] sq_root_r [0:SqrtN];
  side_t           sd_r      [0:SqrtN];
  logic            sq_vld_r  [0:SqrtN];
  side_t           sd_in;
  logic [52:0]     ssum;

  always_comb begin
    ssum = 53'(p5_sq_r[0]) + 53'(p5_sq_r[1]) + 53'(p5_sq_r[2]);
    for (int i = 0; i < 3; i++) begin
      sd_in.n[i]   = p5_n_r[i];
      sd_in.b[i]   = p5_b_r[i];
      sd_in.col[i] = p5_col_r[i];
      sd_in.v[i]   = p5_v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sq_vld_r[0] <= 1'b0;
    else if (en) sq_vld_r[0] <= p5_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0]  <= {ssum[50:0], 12'd0} + 64'd0;
      sq_root_r[0] <= '0;
      sd_r[0]      <= sd_in;
    end
  end

  for (genvar j = 0; j < SqrtN; j++) begin : g_sqrt
    localparam logic [RemW-1:0] BIT = 64'd1 << (62 - 2 * j);
    logic [RemW-1:0] trial, rem_nxt, root_nxt;
    always_comb begin
      trial = sq_root_r[j] + BIT;
      if (sq_rem_r[j] >= trial) begin
        rem_nxt  = sq_rem_r[j] - trial;
        root_nxt = (sq_root_r[j] >> 1) + BIT;
      end else begin
        rem_nxt  = sq_rem_r[j];
        root_nxt = sq_root_r[j] >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sq_vld_r[j+1] <= 1'b0;
      else if (en) sq_vld_r[j+1] <= sq_vld_r[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[j+1]  <= rem_nxt;
        sq_root_r[j+1] <= root_nxt;
        sd_r[j+1]      <= sd_r[j];
      end
    end
  end

  // ---------------- divider setup + divide ----------------
  logic [NumW-1:0] dv_num_r [0:QW][3];
  logic [QW-1:0]   dv_q_r   [0:QW][3];
  logic [2:0]      dv_neg_r [0:QW];
  logic [LenW-1:0] dv_len_r [0:QW];
  side_t           dsd_r    [0:QW];
  logic            dv_vld_r [0:QW];
  logic [LenW-1:0] len_in;
  logic [NumW-1:0] num_in [3];
  logic [2:0]      neg_in;
  logic signed [VW-1:0] vs;
  logic [VW-1:0]        vmag;

  always_comb begin
    len_in = sq_root_r[SqrtN][LenW-1:0];
    vs = '0; vmag = '0;
    for (int i = 0; i < 3; i++) begin
      vs        = $signed(sd_r[SqrtN].v[i]);
      neg_in[i] = vs[VW-1];
      vmag      = vs[VW-1] ? VW'(-vs) : VW'(vs);
      num_in[i] = {vmag[25:0], 20'd0} + 46'(len_in >> 1) + 48'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else if (en) dv_vld_r[0] <= sq_vld_r[SqrtN];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dv_num_r[0] <= num_in;
      for (int i = 0; i < 3; i++) dv_q_r[0][i] <= '0;
      dv_neg_r[0] <= neg_in;
      dv_len_r[0] <= len_in;
      dsd_r[0]    <= sd_r[SqrtN];
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int K = QW - 1 - s;
    logic [NumW-1:0] dvs;
    logic [NumW-1:0] num_nxt [3];
    logic [QW-1:0]   q_nxt [3];
    always_comb begin
      dvs = NumW'(dv_len_r[s]) << K;
      for (int i = 0; i < 3; i++) begin
        num_nxt[i] = dv_num_r[s][i];
        q_nxt[i]   = dv_q_r[s][i];
        if (dv_num_r[s][i] >= dvs) begin
          num_nxt[i]  = dv_num_r[s][i] - dvs;
          q_nxt[i][K] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[s+1] <= 1'b0;
      else if (en) dv_vld_r[s+1] <= dv_vld_r[s];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_num_r[s+1] <= num_nxt;
        dv_q_r[s+1]   <= q_nxt;
        dv_neg_r[s+1] <= dv_neg_r[s];
        dv_len_r[s+1] <= dv_len_r[s];
        dsd_r[s+1]    <= dsd_r[s];
      end
    end
  end

  // ---------------- output ----------------
  logic signed [VecW-1:0] on_nxt [3], ob_nxt [3];
  logic [VecW-1:0]        qcl;
  side_t                  fs;

  always_comb begin
    fs  = dsd_r[QW];
    qcl = '0;
    for (int i = 0; i < 3; i++) begin
      qcl = (dv_q_r[QW][i] > 16'd16384) ? 16'd16384 : dv_q_r[QW][i];
      if (!use_map_r) begin
        on_nxt[i] = $signed(fs.n[i]);
        ob_nxt[i] = '0;
      end else begin
        ob_nxt[i] = $signed(fs.b[i]);
        if (dv_len_r[QW] == '0) on_nxt[i] = '0;
        else on_nxt[i] = dv_neg_r[QW][i] ? -$signed(qcl) : $signed(qcl);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= dv_vld_r[QW];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_normal_x    <= on_nxt[0];
      out_normal_y    <= on_nxt[1];
      out_normal_z    <= on_nxt[2];
      out_bitangent_x <= ob_nxt[0];
      out_bitangent_y <= ob_nxt[1];
      out_bitangent_z <= ob_nxt[2];
      out_color_red   <= fs.col[0];
      out_color_green <= fs.col[1];
      out_color_blue  <= fs.col[2];
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

// Scoreboard for the shading setup unit: predicts the tinted color, the
// bitangent and the (optionally) perturbed normal for each accepted word,
// then checks the output words in order.
class shading_scoreboard;
  typedef struct {
    logic [15:0] nx, ny, nz, bx, by, bz, cr, cg, cb;
  } shade_t;

  shade_t pending[$];
  int errors;
  int checked;
  logic [15:0] base_r, base_g, base_b;
  bit tex_on, map_on;

  function new();
    errors = 0;
    checked = 0;
    base_r = 16'd4096;
    base_g = 16'd4096;
    base_b = 16'd4096;
    tex_on = 0;
    map_on = 0;
  endfunction

  function longint rdiv(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function longint clamp1(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function longint int_sqrt(longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function logic [15:0] tint(logic [15:0] base, logic [7:0] tx);
    longint unsigned p;
    if (!tex_on) return base;
    p = (longint'(base) * tx + 127) / 255;
    return p[15:0];
  endfunction

  // Note one accepted word and push its expected output.
  function void note_hit(logic signed [15:0] nv[3], logic signed [15:0] tv[3],
                         logic [7:0] mp[3], logic [7:0] tx[3]);
    longint n[3], t[3], b[3], r[3], e[3], v[3];
    longint unsigned s, len;
    shade_t x;
    for (int i = 0; i < 3; i++) begin
      n[i] = nv[i];
      t[i] = tv[i];
      r[i] = n[i];
      b[i] = 0;
    end
    if (map_on) begin
      b[0] = clamp1(rdiv(n[1] * t[2] - n[2] * t[1], 16384));
      b[1] = clamp1(rdiv(n[2] * t[0] - n[0] * t[2], 16384));
      b[2] = clamp1(rdiv(n[0] * t[1] - n[1] * t[0], 16384));
      s = 0;
      for (int i = 0; i < 3; i++) e[i] = 2 * longint'(mp[i]) - 255;
      for (int i = 0; i < 3; i++) begin
        v[i] = t[i] * e[0] + b[i] * e[1] + n[i] * e[2];
        s += v[i] * v[i];
      end
      len = int_sqrt(s << 12);
      for (int i = 0; i < 3; i++)
        r[i] = (len == 0) ? 0 : clamp1(rdiv(v[i] * (longint'(1) << 20), len));
    end
    x.nx = r[0][15:0]; x.ny = r[1][15:0]; x.nz = r[2][15:0];
    x.bx = b[0][15:0]; x.by = b[1][15:0]; x.bz = b[2][15:0];
    x.cr = tint(base_r, tx[0]);
    x.cg = tint(base_g, tx[1]);
    x.cb = tint(base_b, tx[2]);
    pending.push_back(x);
  endfunction

  function void cmp(string name, logic [15:0] e, logic [15:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", name, e, a);
      errors++;
    end
  endfunction

  function void check_word(shade_t a);
    shade_t e;
    if (pending.size() == 0) begin
      $error("output word with nothing expected");
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    cmp("out_normal_x", e.nx, a.nx);
    cmp("out_normal_y", e.ny, a.ny);
    cmp("out_normal_z", e.nz, a.nz);
    cmp("out_bitangent_x", e.bx, a.bx);
    cmp("out_bitangent_y", e.by, a.by);
    cmp("out_bitangent_z", e.bz, a.bz);
    cmp("out_color_red", e.cr, a.cr);
    cmp("out_color_green", e.cg, a.cg);
    cmp("out_color_blue", e.cb, a.cb);
  endfunction
endclass

module tb_top;
  import nmss_pkg::*;

  localparam int LATENCY = 56;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDatW-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] in_normal_x = 0, in_normal_y = 0, in_normal_z = 0;
  logic signed [15:0] in_tangent_x = 0, in_tangent_y = 0, in_tangent_z = 0;
  logic [7:0] in_map_red = 0, in_map_green = 0, in_map_blue = 0;
  logic [7:0] in_tex_red = 0, in_tex_green = 0, in_tex_blue = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] out_normal_x, out_normal_y, out_normal_z;
  logic signed [15:0] out_bitangent_x, out_bitangent_y, out_bitangent_z;
  logic [15:0] out_color_red, out_color_green, out_color_blue;

  shading_scoreboard sb = new();
  int stall_mode = 0;
  int words_sent = 0;

  normal_map_shading_setup_unit dut (.*);

  always #2 clk = ~clk;

  // Monitor: input acceptance feeds the predictor, output acceptance is checked.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_hit('{in_normal_x, in_normal_y, in_normal_z},
                  '{in_tangent_x, in_tangent_y, in_tangent_z},
                  '{in_map_red, in_map_green, in_map_blue},
                  '{in_tex_red, in_tex_green, in_tex_blue});
      words_sent++;
    end
    if (rst_n && out_valid && !out_stall)
      sb.check_word('{out_normal_x, out_normal_y, out_normal_z,
                      out_bitangent_x, out_bitangent_y, out_bitangent_z,
                      out_color_red, out_color_green, out_color_blue});
  end

  // Receiver stall pattern: switches between free-running, light and heavy
  // stall, plus a third random mode that stalls about three times in seven.
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ($urandom_range(0, 6) < 3);
    endcase
  end

  // Write enable stays high across a group of writes; the caller drops it.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_BASE_RED:   sb.base_r = val;
      REG_BASE_GREEN: sb.base_g = val;
      REG_BASE_BLUE:  sb.base_b = val;
      REG_USE_TEX:    sb.tex_on = val[0];
      default:        sb.map_on = val[0];
    endcase
  endtask

  // Present one word and hold it until taken; valid stays high across
  // back-to-back words, lowered only when a gap follows.
  task automatic send_word(logic signed [15:0] n[3], logic signed [15:0] t[3],
                           logic [7:0] mp[3], logic [7:0] tx[3], bit hold);
    in_valid <= 1'b1;
    {in_normal_x, in_normal_y, in_normal_z} <= {n[0], n[1], n[2]};
    {in_tangent_x, in_tangent_y, in_tangent_z} <= {t[0], t[1], t[2]};
    {in_map_red, in_map_green, in_map_blue} <= {mp[0], mp[1], mp[2]};
    {in_tex_red, in_tex_green, in_tex_blue} <= {tx[0], tx[1], tx[2]};
    do @(posedge clk); while (in_stall);
    if (!hold) in_valid <= 1'b0;
  endtask

  // Random unit-ish vector; mostly near unit length, sometimes raw bits.
  function automatic void rand_vec(output logic signed [15:0] v[3]);
    int k;
    k = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      if (k == 0) v[i] = 16'($urandom);
      else if (k == 1) v[i] = 16'($signed($urandom_range(0, 32768)) - 16384);
      else v[i] = 16'($signed($urandom_range(0, 18000)) - 9000);
    end
    if (k == 2) begin
      v = '{0, 0, 0};
      v[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    end
  endfunction

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    logic signed [15:0] n[3], t[3];
    logic [7:0] mp[3], tx[3];
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && count > 0) begin
        rand_vec(n);
        rand_vec(t);
        for (int i = 0; i < 3; i++) begin
          mp[i] = 8'($urandom);
          tx[i] = 8'($urandom);
        end
        burst--;
        count--;
        send_word(n, t, mp, tx, burst > 0 && count > 0);
      end
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  initial begin
    logic signed [15:0] n[3], t[3];
    logic [7:0] mp[3], tx[3];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pass-through at reset config, then extremes with all modes on.
    n = '{16384, 0, 0}; t = '{0, 16384, 0};
    mp = '{128, 128, 255}; tx = '{255, 0, 128};
    send_word(n, t, mp, tx, 1);
    n = '{-32768, 32767, -1}; t = '{32767, -32768, 1};
    send_word(n, t, mp, tx, 0);
    drain();
    write_reg(REG_BASE_RED, 16'hFFFF);
    write_reg(REG_BASE_GREEN, 16'h0000);
    write_reg(REG_BASE_BLUE, 16'h1000);
    write_reg(REG_USE_TEX, 16'd1);
    write_reg(REG_USE_MAP, 16'd1);
    cfg_we <= 1'b0;
    n = '{0, 0, 16384}; t = '{16384, 0, 0};
    mp = '{128, 128, 255}; tx = '{255, 255, 255};
    send_word(n, t, mp, tx, 1);
    mp = '{0, 0, 0}; tx = '{0, 0, 0};
    send_word(n, t, mp, tx, 1);
    mp = '{255, 255, 0}; tx = '{1, 127, 254};
    send_word(n, t, mp, tx, 1);
    n = '{0, 0, 0}; t = '{0, 0, 0}; // degenerate frame
    send_word(n, t, mp, tx, 1);
    n = '{-16384, -16384, -16384}; t = '{16384, -16384, 16384};
    mp = '{255, 0, 255};
    send_word(n, t, mp, tx, 1);
    n = '{32767, 32767, 32767}; t = '{-32768, -32768, 32767};
    send_word(n, t, mp, tx, 1);
    n = '{11585, 0, 11585}; t = '{11585, 0, -11585};
    mp = '{127, 128, 200}; tx = '{170, 85, 51};
    send_word(n, t, mp, tx, 0);
    drain();

    // Random phases over several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_BASE_RED, (ph == 1) ? 16'hFFFF : 16'($urandom));
      write_reg(REG_BASE_GREEN, (ph == 2) ? 16'h0000 : 16'($urandom));
      write_reg(REG_BASE_BLUE, 16'($urandom));
      write_reg(REG_USE_TEX, 16'(ph[0]));
      write_reg(REG_USE_MAP, 16'(ph != 3));
      cfg_we <= 1'b0;
      random_phase(250);
      drain();
    end

    $display("Covered %0d words and %0d checked results across texture/map modes.",
             words_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end
endmodule
